[rtl/rrp_pkg.sv]
// Shared types and constants for the reply parser.
package rrp_pkg;

  localparam logic [7:0] CH_ARRAY  = 8'h2A;
  localparam logic [7:0] CH_SIMPLE = 8'h2B;
  localparam logic [7:0] CH_ERRSTR = 8'h2D;
  localparam logic [7:0] CH_INT    = 8'h3A;
  localparam logic [7:0] CH_BULK   = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [2:0] T_NONE   = 3'd0;
  localparam logic [2:0] T_ARRAY  = 3'd1;
  localparam logic [2:0] T_SIMPLE = 3'd2;
  localparam logic [2:0] T_ERRSTR = 3'd3;
  localparam logic [2:0] T_INT    = 3'd4;
  localparam logic [2:0] T_BULK   = 3'd5;

  localparam logic [1:0] ST_CONT = 2'd0;
  localparam logic [1:0] ST_ELEM = 2'd1;
  localparam logic [1:0] ST_MSG  = 2'd2;
  localparam logic [1:0] ST_ERR  = 2'd3;

  // Byte class computed by the front end.
  typedef struct packed {
    logic [7:0] data;
    logic       is_digit;
    logic [3:0] digit;
    logic       is_cr;
    logic       is_lf;
    logic       is_minus;
    logic [2:0] type_code;
  } byte_info_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  element_type;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        value_valid;
    logic [31:0] value;
    logic        is_null;
    logic [3:0]  nest_level;
  } result_t;

endpackage

[rtl/rrp_front.sv]
// Front end: byte classifier with a two-entry queue toward the parser.
module rrp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                data_valid,
  output logic                data_ready,
  input  logic [7:0]          data_byte,
  output logic                q_valid,
  input  logic                q_ready,
  output rrp_pkg::byte_info_t q_info
);

  rrp_pkg::byte_info_t cls;
  rrp_pkg::byte_info_t slot [2];
  logic       rd_ptr, wr_ptr;
  logic [1:0] count;
  logic       push, pop;

  always_comb begin
    cls = '0;
    cls.data     = data_byte;
    cls.is_digit = (data_byte >= rrp_pkg::CH_ZERO) && (data_byte <= rrp_pkg::CH_NINE);
    cls.digit    = 4'(data_byte - rrp_pkg::CH_ZERO);
    cls.is_cr    = data_byte == rrp_pkg::CH_CR;
    cls.is_lf    = data_byte == rrp_pkg::CH_LF;
    cls.is_minus = data_byte == rrp_pkg::CH_ERRSTR;
    unique case (data_byte)
      rrp_pkg::CH_ARRAY:  cls.type_code = rrp_pkg::T_ARRAY;
      rrp_pkg::CH_SIMPLE: cls.type_code = rrp_pkg::T_SIMPLE;
      rrp_pkg::CH_ERRSTR: cls.type_code = rrp_pkg::T_ERRSTR;
      rrp_pkg::CH_INT:    cls.type_code = rrp_pkg::T_INT;
      rrp_pkg::CH_BULK:   cls.type_code = rrp_pkg::T_BULK;
      default:            cls.type_code = rrp_pkg::T_NONE;
    endcase
  end

  assign data_ready = count != 2'd2;
  assign q_valid    = count != 2'd0;
  assign q_info     = slot[rd_ptr];
  assign push       = data_valid && data_ready;
  assign pop        = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= cls;
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

[rtl/rrp_back.sv]
// Back end: parser state machine, array count stack and output register.
module rrp_back #(
  parameter int MAX_DEPTH = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_ready,
  input  rrp_pkg::byte_info_t q_info,
  output logic                out_valid,
  input  logic                out_ready,
  output rrp_pkg::result_t    out_res
);

  localparam int LW = $clog2(MAX_DEPTH + 1);
  localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_NUM     = 3'd1;
  localparam logic [2:0] PH_NUM_LF  = 3'd2;
  localparam logic [2:0] PH_LINE    = 3'd3;
  localparam logic [2:0] PH_LINE_LF = 3'd4;
  localparam logic [2:0] PH_BULK    = 3'd5;
  localparam logic [2:0] PH_BULK_CR = 3'd6;
  localparam logic [2:0] PH_BULK_LF = 3'd7;

  logic [2:0]  phase, phase_next;
  logic [2:0]  cur_type, cur_type_next;
  logic        neg, neg_next;
  logic        seen, seen_next;
  logic [31:0] acc, acc_next;
  logic [31:0] bulk_rem, bulk_rem_next;
  logic [LW-1:0] level, level_next;

  // Stack entries, each read at its own place for the close walk.
  logic [31:0] stack [MAX_DEPTH];
  logic [MAX_DEPTH-1:0] is_one;   // entry count is at most one
  logic        push_en;
  logic [31:0] push_val;

  logic        take;
  logic        finish;
  logic        err;
  rrp_pkg::result_t res;

  logic [35:0] prod;
  logic [32:0] lim;
  logic        isneg;

  assign take    = q_valid && q_ready;
  assign q_ready = !out_valid || out_ready;

  always_comb begin
    for (int i = 0; i < MAX_DEPTH; i++) is_one[i] = stack[i] <= 32'd1;
  end

  always_comb begin
    phase_next    = phase;
    cur_type_next = cur_type;
    neg_next      = neg;
    seen_next     = seen;
    acc_next      = acc;
    bulk_rem_next = bulk_rem;
    level_next    = level;
    push_en  = 1'b0;
    push_val = acc;
    finish   = 1'b0;
    err      = 1'b0;
    res      = '0;
    res.element_type = cur_type;
    prod  = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + 36'(q_info.digit);
    lim   = neg ? 33'h080000000 : 33'h07FFFFFFF;
    isneg = neg && (acc != 32'd0);
    unique case (phase)
      PH_IDLE: begin
        if (q_info.type_code == rrp_pkg::T_NONE) begin
          err = 1'b1;
        end else begin
          cur_type_next    = q_info.type_code;
          res.element_type = q_info.type_code;
          phase_next = (q_info.type_code == rrp_pkg::T_SIMPLE ||
                        q_info.type_code == rrp_pkg::T_ERRSTR) ? PH_LINE : PH_NUM;
        end
      end
      PH_NUM: begin
        if (q_info.is_minus && !seen && !neg) neg_next = 1'b1;
        else if (q_info.is_digit) begin
          if (prod > 36'(lim)) err = 1'b1;
          else begin
            acc_next  = prod[31:0];
            seen_next = 1'b1;
          end
        end else if (q_info.is_cr && seen) phase_next = PH_NUM_LF;
        else err = 1'b1;
      end
      PH_NUM_LF: begin
        if (!q_info.is_lf) err = 1'b1;
        else begin
          res.value_valid = 1'b1;
          res.value = isneg ? (32'd0 - acc) : acc;
          if (cur_type == rrp_pkg::T_INT) finish = 1'b1;
          else if (cur_type == rrp_pkg::T_ARRAY) begin
            if (isneg) begin
              if (acc == 32'd1) begin
                res.is_null = 1'b1;
                finish = 1'b1;
              end else err = 1'b1;
            end else if (acc == 32'd0) finish = 1'b1;
            else if (level >= LW'(MAX_DEPTH)) err = 1'b1;
            else begin
              push_en = 1'b1;
              push_val = acc;
              level_next = level + LW'(1);
              phase_next = PH_IDLE; cur_type_next = rrp_pkg::T_NONE;
              neg_next = 1'b0; seen_next = 1'b0; acc_next = '0; bulk_rem_next = '0;
            end
          end else if (cur_type == rrp_pkg::T_BULK) begin
            if (isneg) begin
              if (acc == 32'd1) begin
                res.is_null = 1'b1;
                finish = 1'b1;
              end else err = 1'b1;
            end else if (acc == 32'd0) phase_next = PH_BULK_CR;
            else begin
              bulk_rem_next = acc;
              phase_next = PH_BULK;
            end
          end else err = 1'b1;
        end
      end
      PH_LINE: begin
        if (q_info.is_cr) phase_next = PH_LINE_LF;
        else begin
          res.payload_valid = 1'b1;
          res.payload_byte  = q_info.data;
        end
      end
      PH_LINE_LF: begin
        if (q_info.is_lf) finish = 1'b1;
        else err = 1'b1;
      end
      PH_BULK: begin
        res.payload_valid = 1'b1;
        res.payload_byte  = q_info.data;
        if (bulk_rem <= 32'd1) begin
          bulk_rem_next = '0;
          phase_next = PH_BULK_CR;
        end else bulk_rem_next = bulk_rem - 32'd1;
      end
      PH_BULK_CR: begin
        if (q_info.is_cr) phase_next = PH_BULK_LF;
        else err = 1'b1;
      end
      PH_BULK_LF: begin
        if (q_info.is_lf) finish = 1'b1;
        else err = 1'b1;
      end
      default: err = 1'b1;
    endcase

    if (finish) begin
      phase_next = PH_IDLE; cur_type_next = rrp_pkg::T_NONE;
      neg_next = 1'b0; seen_next = 1'b0; acc_next = '0; bulk_rem_next = '0;
      // Close every array from the top whose count runs out.
      level_next = level;
      for (int i = MAX_DEPTH - 1; i >= 0; i--) begin
        if (level_next == LW'(i + 1) && is_one[i]) level_next = LW'(i);
      end
      res.status = (level_next == '0) ? rrp_pkg::ST_MSG : rrp_pkg::ST_ELEM;
    end
    if (err) begin
      res = '0;
      res.element_type = cur_type;
      res.status = rrp_pkg::ST_ERR;
      phase_next = PH_IDLE; cur_type_next = rrp_pkg::T_NONE;
      neg_next = 1'b0; seen_next = 1'b0; acc_next = '0; bulk_rem_next = '0;
      level_next = '0;
      push_en = 1'b0;
    end
    res.nest_level = 4'(level_next);
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (push_en) stack[IW'(level)] <= push_val;
      else if (finish) begin
        // Decrement the open arrays that stay open (top survivor only).
        for (int i = 0; i < MAX_DEPTH; i++) begin
          if (LW'(i + 1) == level_next && LW'(i) < level && !is_one[i])
            stack[i] <= stack[i] - 32'd1;
        end
      end
      out_res <= res;
    end
    if (rst) begin
      phase     <= PH_IDLE;
      cur_type  <= rrp_pkg::T_NONE;
      neg       <= 1'b0;
      seen      <= 1'b0;
      acc       <= '0;
      bulk_rem  <= '0;
      level     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        phase    <= phase_next;
        cur_type <= cur_type_next;
        neg      <= neg_next;
        seen     <= seen_next;
        acc      <= acc_next;
        bulk_rem <= bulk_rem_next;
        level    <= level_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/resp_reply_parser.sv]
// Top level of the streaming reply parser.
//
// Input channel: data_valid/data_ready carry one raw reply byte (data_byte)
// per request. Output channel: out_valid/out_ready carry one result per
// input byte: status, element_type, payload and value fields, is_null and
// nest_level after that byte.
//
// A front end classifies each byte (digit, CR, LF, type marks) and parks it
// in a two-entry queue. The back end runs the parse state machine, keeps
// the stack of remaining-element counts for open arrays (MAX_DEPTH entries)
// and holds the result in an output register.
//
// Throughput: one byte per cycle while the receiver takes each result, set
// by the back end, which updates its state for each byte it takes; a stall
// on out_ready holds the flow. A byte accepted at the input is first written
// into the queue, then the back end registers its result.
//
// Reset clears the parse state, the queue and the depth; stack entries
// are only read below the current depth. When the receiver stalls the
// output register holds, the queue fills and data_ready drops after two.
module resp_reply_parser #(
  parameter int MAX_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_ready,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [2:0]  element_type,
  output logic        payload_valid,
  output logic [7:0]  payload_byte,
  output logic        value_valid,
  output logic signed [31:0] value,
  output logic        is_null,
  output logic [3:0]  nest_level
);

  logic                q_valid, q_ready;
  rrp_pkg::byte_info_t q_info;
  rrp_pkg::result_t    res;

  rrp_front u_front (
    .clk(clk), .rst(rst),
    .data_valid(data_valid), .data_ready(data_ready), .data_byte(data_byte),
    .q_valid(q_valid), .q_ready(q_ready), .q_info(q_info)
  );

  rrp_back #(.MAX_DEPTH(MAX_DEPTH)) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready), .q_info(q_info),
    .out_valid(out_valid), .out_ready(out_ready), .out_res(res)
  );

  assign status        = res.status;
  assign element_type  = res.element_type;
  assign payload_valid = res.payload_valid;
  assign payload_byte  = res.payload_byte;
  assign value_valid   = res.value_valid;
  assign value         = res.value;
  assign is_null       = res.is_null;
  assign nest_level    = res.nest_level;

endmodule

[rtl/rrp_checker.sv]
// Port-level checks for the reply parser, bound to the top level.
module rrp_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] status,
  input logic       payload_valid,
  input logic       value_valid,
  input logic       is_null,
  input logic [3:0] nest_level
);

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == rrp_pkg::ST_ERR |->
      !payload_valid && !value_valid && !is_null && nest_level == 4'd0)
    else $error("error result not clean");

  a_msg_level: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == rrp_pkg::ST_MSG |-> nest_level == 4'd0)
    else $error("message end with open array");

  a_null_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_null |-> value_valid)
    else $error("null without value");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("stalled result changed");

endmodule

bind resp_reply_parser rrp_checker u_chk (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_ready(out_ready),
  .status(status), .payload_valid(payload_valid), .value_valid(value_valid),
  .is_null(is_null), .nest_level(nest_level)
);
